@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the bounding rectangle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that an implication property holds on every clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that a signal is never high while another signal is high.
`define ASSERT_NEVER_BOTH(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) else $error(msg);

`endif

@@ hw/rtl/mabr_pkg.sv @@
// ----------------------------------------------------------------------------
// mabr_pkg
// Shared types, constants and the Q1.15 sine table of the bounding rectangle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mabr_pkg;

  localparam int unsigned MaxPointsDef  = 2048;
  localparam int unsigned AngleStepsDef = 90;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned CornerW = 18;
  localparam int unsigned AngleW  = 7;
  localparam int unsigned AreaW   = 33;
  localparam int unsigned MarginW = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 33;
  localparam int unsigned RotW    = 18;
  localparam logic [CfgIdxW-1:0] CfgMargin = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgArea   = 1'd1;
  localparam logic [MarginW-1:0] MarginReset = 10'd50;
  localparam logic [AreaW-1:0]   AreaReset   = 33'd2500000000;
  localparam int signed CornerLim = 70000;

  typedef enum logic [3:0] {
    StIdle,
    StStore,
    StRead,
    StScan,
    StDrain,
    StArea,
    StCompare,
    StCorner,
    StCornerRnd,
    StEmit
  } state_e;

  // Control from the sequencer to the rotation datapath.
  typedef struct packed {
    logic first;
    logic take;
  } scan_ctl_t;

  // Sine of d degrees, 0..180, Q1.15 with 1.0 held as 32767.
  function automatic logic [15:0] sin_q15(input logic [7:0] d);
    logic [6:0] k;
    logic [15:0] r;
    k = (d > 8'd90) ? 7'(8'd180 - d) : d[6:0];
    case (k)
      7'd0: r = 0; 7'd1: r = 572; 7'd2: r = 1144; 7'd3: r = 1715; 7'd4: r = 2286;
      7'd5: r = 2856; 7'd6: r = 3425; 7'd7: r = 3993; 7'd8: r = 4560; 7'd9: r = 5126;
      7'd10: r = 5690; 7'd11: r = 6252; 7'd12: r = 6813; 7'd13: r = 7371;
      7'd14: r = 7927; 7'd15: r = 8481; 7'd16: r = 9032; 7'd17: r = 9580;
      7'd18: r = 10126; 7'd19: r = 10668; 7'd20: r = 11207; 7'd21: r = 11743;
      7'd22: r = 12275; 7'd23: r = 12803; 7'd24: r = 13328; 7'd25: r = 13848;
      7'd26: r = 14365; 7'd27: r = 14876; 7'd28: r = 15384; 7'd29: r = 15886;
      7'd30: r = 16384; 7'd31: r = 16877; 7'd32: r = 17364; 7'd33: r = 17847;
      7'd34: r = 18324; 7'd35: r = 18795; 7'd36: r = 19261; 7'd37: r = 19720;
      7'd38: r = 20174; 7'd39: r = 20622; 7'd40: r = 21063; 7'd41: r = 21498;
      7'd42: r = 21926; 7'd43: r = 22348; 7'd44: r = 22763; 7'd45: r = 23170;
      7'd46: r = 23571; 7'd47: r = 23965; 7'd48: r = 24351; 7'd49: r = 24730;
      7'd50: r = 25102; 7'd51: r = 25466; 7'd52: r = 25822; 7'd53: r = 26170;
      7'd54: r = 26510; 7'd55: r = 26842; 7'd56: r = 27166; 7'd57: r = 27482;
      7'd58: r = 27789; 7'd59: r = 28088; 7'd60: r = 28378; 7'd61: r = 28660;
      7'd62: r = 28932; 7'd63: r = 29197; 7'd64: r = 29452; 7'd65: r = 29698;
      7'd66: r = 29935; 7'd67: r = 30163; 7'd68: r = 30382; 7'd69: r = 30592;
      7'd70: r = 30792; 7'd71: r = 30983; 7'd72: r = 31164; 7'd73: r = 31336;
      7'd74: r = 31499; 7'd75: r = 31651; 7'd76: r = 31795; 7'd77: r = 31928;
      7'd78: r = 32052; 7'd79: r = 32166; 7'd80: r = 32270; 7'd81: r = 32365;
      7'd82: r = 32449; 7'd83: r = 32524; 7'd84: r = 32588; 7'd85: r = 32643;
      7'd86: r = 32688; 7'd87: r = 32723; 7'd88: r = 32748; 7'd89: r = 32763;
      default: r = 32767;
    endcase
    return r;
  endfunction

  // Cosine of d degrees, 0..180, Q1.15; negative past 90 degrees.
  function automatic logic signed [15:0] cos_q15(input logic [7:0] d);
    logic signed [15:0] r;
    if (d <= 8'd90) begin
      r = $signed(sin_q15(8'd90 - d));
    end else begin
      r = -$signed(sin_q15(d - 8'd90));
    end
    return r;
  endfunction

  // Round a Q.15 product sum to whole units, halves toward plus infinity.
  function automatic logic signed [RotW-1:0] rnd15(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = v + 36'sd16384;
    return RotW'(t >>> 15);
  endfunction

endpackage

@@ hw/rtl/mabr_ram.sv @@
// ----------------------------------------------------------------------------
// mabr_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mabr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One access per cycle: a write when enabled, and always a registered read of the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mabr_rot.sv @@
// ----------------------------------------------------------------------------
// mabr_rot
// Rotation of one stored point per cycle and running extent tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mabr_rot (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mabr_pkg::scan_ctl_t           ctl_i,
  input  logic signed [15:0]            cos_i,
  input  logic signed [15:0]            sin_i,
  input  logic signed [15:0]            x_i,
  input  logic signed [15:0]            y_i,
  output logic signed [mabr_pkg::RotW-1:0] min_u_o,
  output logic signed [mabr_pkg::RotW-1:0] max_u_o,
  output logic signed [mabr_pkg::RotW-1:0] min_v_o,
  output logic signed [mabr_pkg::RotW-1:0] max_v_o
);

  logic signed [31:0] cx_q, sy_q, sx_q, cy_q;
  logic take_q, first_q, tk2_q, fs2_q;
  logic signed [mabr_pkg::RotW-1:0] u_q, v_q;
  logic signed [mabr_pkg::RotW-1:0] mnu_q, mxu_q, mnv_q, mxv_q;

  // Products registered before the add and round.
  always_ff @(posedge clk_i) begin
    cx_q <= cos_i * x_i;
    sy_q <= sin_i * y_i;
    sx_q <= sin_i * x_i;
    cy_q <= cos_i * y_i;
    u_q  <= mabr_pkg::rnd15(36'(cx_q) - 36'(sy_q));
    v_q  <= mabr_pkg::rnd15(36'(sx_q) + 36'(cy_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_q <= 1'b0; first_q <= 1'b0; tk2_q <= 1'b0; fs2_q <= 1'b0;
    end else begin
      take_q <= ctl_i.take; first_q <= ctl_i.first;
      tk2_q <= take_q; fs2_q <= first_q;
    end
  end

  // Running extents over the points of one angle.
  always_ff @(posedge clk_i) begin
    if (tk2_q) begin
      if (fs2_q || u_q < mnu_q) mnu_q <= u_q;
      if (fs2_q || u_q > mxu_q) mxu_q <= u_q;
      if (fs2_q || v_q < mnv_q) mnv_q <= v_q;
      if (fs2_q || v_q > mxv_q) mxv_q <= v_q;
    end
  end

  assign min_u_o = mnu_q;
  assign max_u_o = mxu_q;
  assign min_v_o = mnv_q;
  assign max_v_o = mxv_q;

endmodule

@@ hw/rtl/min_area_bounding_rectangle.sv @@
// ----------------------------------------------------------------------------
// min_area_bounding_rectangle
// Rotating-axes search for the smallest box around a stored point set.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// point     in         start while busy is low
// result    out        done_o strobe, one cycle, no stall
// config    in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// A point that is not last keeps busy high for 1 cycle, after which the next
// point can be started. A closing point keeps busy high for the whole search,
// whose length is set by the one read port of the point memory: each stored
// point is read once per angle, and each angle adds read setup, pipeline
// drain, area and compare.
// Reset clears the control state and the point count; memories are not cleared.
// The result is shown in the last busy cycle on done_o and cannot be stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module min_area_bounding_rectangle #(
  parameter int unsigned MaxPoints  = mabr_pkg::MaxPointsDef,
  parameter int unsigned AngleSteps = mabr_pkg::AngleStepsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mabr_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [mabr_pkg::CoordW-1:0]  point_y_i,
  input  logic                                last_point_i,
  input  logic                                cfg_we_i,
  input  logic [mabr_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mabr_pkg::CfgDatW-1:0]        cfg_data_i,
  output logic                                done_o,
  output logic signed [mabr_pkg::CornerW-1:0] corner1_x_o,
  output logic signed [mabr_pkg::CornerW-1:0] corner1_y_o,
  output logic signed [mabr_pkg::CornerW-1:0] corner2_x_o,
  output logic signed [mabr_pkg::CornerW-1:0] corner2_y_o,
  output logic signed [mabr_pkg::CornerW-1:0] corner3_x_o,
  output logic signed [mabr_pkg::CornerW-1:0] corner3_y_o,
  output logic signed [mabr_pkg::CornerW-1:0] corner4_x_o,
  output logic signed [mabr_pkg::CornerW-1:0] corner4_y_o,
  output logic [mabr_pkg::AngleW-1:0]         best_angle_o,
  output logic [mabr_pkg::AreaW-1:0]          best_area_o,
  output logic                                found_o
);

  localparam int unsigned AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);
  localparam int unsigned AngW  = (AngleSteps > 1) ? $clog2(AngleSteps) : 1;
  localparam int unsigned RW    = mabr_pkg::RotW;

  mabr_pkg::state_e state_q, state_d;
  logic [mabr_pkg::MarginW-1:0] margin_q;
  logic [mabr_pkg::AreaW-1:0]   limit_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  idx_q;
  logic [AngW-1:0]  ang_q;
  logic [2:0]       drain_q;
  logic             last_q, found_q;
  logic signed [15:0] px_q, py_q;
  logic [33:0]      best_area_q;
  logic [AngW-1:0]  best_ang_q;
  logic signed [RW-1:0] bnd_q [4];
  logic signed [RW+1:0] du_q, dv_q;
  logic [39:0]      area_q;
  logic [1:0]       k_q;
  logic signed [35:0] acx_q, acy_q;
  logic signed [RW-1:0] cx_q [4];
  logic signed [RW-1:0] cy_q [4];

  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [15:0]      rx, ry;
  logic signed [15:0] c_w, s_w, bc_w, bs_w;
  logic signed [RW-1:0] mnu, mxu, mnv, mxv;
  mabr_pkg::scan_ctl_t ctl;
  logic signed [RW-1:0] pu, pv;
  logic signed [RW:0]   mg, pum, pvm;
  logic signed [RW:0]   rcx, rcy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= mabr_pkg::MarginReset;
      limit_q  <= mabr_pkg::AreaReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mabr_pkg::CfgMargin: margin_q <= cfg_data_i[mabr_pkg::MarginW-1:0];
        mabr_pkg::CfgArea:   limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Point memories.
  assign ram_we   = (state_q == mabr_pkg::StStore) && (count_q < CntW'(MaxPoints));
  assign ram_addr = (state_q == mabr_pkg::StStore) ? count_q[AddrW-1:0] : idx_q[AddrW-1:0];

  mabr_ram #(.Width(16), .Depth(MaxPoints)) u_ram_x (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(px_q), .rdata_o(rx));
  mabr_ram #(.Width(16), .Depth(MaxPoints)) u_ram_y (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(py_q), .rdata_o(ry));

  // Sine and cosine of the current and the best angle.
  assign s_w  = mabr_pkg::sin_q15(8'(ang_q));
  assign c_w  = mabr_pkg::cos_q15(8'(ang_q));
  assign bs_w = mabr_pkg::sin_q15(8'(best_ang_q));
  assign bc_w = mabr_pkg::cos_q15(8'(best_ang_q));

  // Reads issued in StRead and StScan return in the next cycle, when rd_q marks them.
  logic rd_q, rd_first_q;
  assign ctl.take  = rd_q;
  assign ctl.first = rd_first_q;

  mabr_rot u_rot (
    .clk_i, .rst_ni, .ctl_i(ctl), .cos_i(c_w), .sin_i(s_w),
    .x_i(rx), .y_i(ry),
    .min_u_o(mnu), .max_u_o(mxu), .min_v_o(mnv), .max_v_o(mxv));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mabr_pkg::StIdle:  if (start) state_d = mabr_pkg::StStore;
      mabr_pkg::StStore: state_d = last_q ? mabr_pkg::StRead : mabr_pkg::StIdle;
      mabr_pkg::StRead:  state_d = mabr_pkg::StScan;
      mabr_pkg::StScan:  if (idx_q == count_q) state_d = mabr_pkg::StDrain;
      mabr_pkg::StDrain: if (drain_q == 3'd3) state_d = mabr_pkg::StArea;
      mabr_pkg::StArea:  state_d = mabr_pkg::StCompare;
      mabr_pkg::StCompare:
        state_d = (ang_q == AngW'(AngleSteps - 1)) ? mabr_pkg::StCorner : mabr_pkg::StRead;
      mabr_pkg::StCorner:    state_d = mabr_pkg::StCornerRnd;
      mabr_pkg::StCornerRnd:
        state_d = (k_q == 2'd3) ? mabr_pkg::StEmit : mabr_pkg::StCorner;
      mabr_pkg::StEmit:  state_d = mabr_pkg::StIdle;
      default: state_d = mabr_pkg::StIdle;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy   = (state_q != mabr_pkg::StIdle);
    done_o = (state_q == mabr_pkg::StEmit);
  end

  // Corner selection for the back rotation, widened by the margin.
  always_comb begin
    pu  = (k_q[1]) ? bnd_q[2] : bnd_q[0];
    pv  = (k_q == 2'd1 || k_q == 2'd2) ? bnd_q[3] : bnd_q[1];
    mg  = (RW+1)'($signed({1'b0, margin_q}));
    pum = k_q[1] ? (RW+1)'(pu) + mg : (RW+1)'(pu) - mg;
    pvm = (k_q == 2'd1 || k_q == 2'd2) ? (RW+1)'(pv) + mg : (RW+1)'(pv) - mg;
  end
  assign rcx = (RW+1)'(mabr_pkg::rnd15(acx_q));
  assign rcy = (RW+1)'(mabr_pkg::rnd15(acy_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mabr_pkg::StIdle;
      count_q <= '0;
      rd_q <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_q <= (state_q == mabr_pkg::StRead) ||
              ((state_q == mabr_pkg::StScan) && (idx_q != count_q));
      rd_first_q <= (state_q == mabr_pkg::StRead);
      if (state_q == mabr_pkg::StStore && count_q < CntW'(MaxPoints)) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == mabr_pkg::StEmit) count_q <= '0;
    end
  end

  // Datapath registers of the search.
  always_ff @(posedge clk_i) begin
    case (state_q)
      mabr_pkg::StIdle: begin
        if (start) begin
          px_q <= point_x_i; py_q <= point_y_i; last_q <= last_point_i;
        end
      end
      mabr_pkg::StStore: begin
        ang_q <= '0;
        idx_q <= '0;
        found_q <= 1'b0;
        best_area_q <= {1'b0, limit_q};
        best_ang_q <= '0;
        for (int j = 0; j < 4; j++) bnd_q[j] <= '0;
      end
      mabr_pkg::StRead: begin
        idx_q <= CntW'(1);
        drain_q <= '0;
      end
      mabr_pkg::StScan: if (idx_q != count_q) idx_q <= idx_q + 1'b1;
      mabr_pkg::StDrain: begin
        drain_q <= drain_q + 1'b1;
        du_q <= (RW+2)'(mxu) - (RW+2)'(mnu);
        dv_q <= (RW+2)'(mxv) - (RW+2)'(mnv);
      end
      mabr_pkg::StArea: area_q <= 40'(du_q[RW:0]) * 40'(dv_q[RW:0]);
      mabr_pkg::StCompare: begin
        if (area_q < 40'(best_area_q)) begin
          best_area_q <= area_q[33:0];
          best_ang_q <= ang_q;
          bnd_q[0] <= mnu; bnd_q[1] <= mnv; bnd_q[2] <= mxu; bnd_q[3] <= mxv;
          found_q <= 1'b1;
        end
        ang_q <= ang_q + 1'b1;
        idx_q <= '0;
        k_q <= '0;
      end
      mabr_pkg::StCorner: begin
        acx_q <= 36'(bc_w * pum) + 36'(bs_w * pvm);
        acy_q <= 36'(bc_w * pvm) - 36'(bs_w * pum);
      end
      mabr_pkg::StCornerRnd: begin
        cx_q[k_q] <= (rcx > (RW+1)'(mabr_pkg::CornerLim)) ? RW'(mabr_pkg::CornerLim) :
                     (rcx < -(RW+1)'(mabr_pkg::CornerLim)) ? -RW'(mabr_pkg::CornerLim) :
                     RW'(rcx);
        cy_q[k_q] <= (rcy > (RW+1)'(mabr_pkg::CornerLim)) ? RW'(mabr_pkg::CornerLim) :
                     (rcy < -(RW+1)'(mabr_pkg::CornerLim)) ? -RW'(mabr_pkg::CornerLim) :
                     RW'(rcy);
        k_q <= k_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Result ports.
  assign corner1_x_o = found_q ? cx_q[0] : '0;
  assign corner1_y_o = found_q ? cy_q[0] : '0;
  assign corner2_x_o = found_q ? cx_q[1] : '0;
  assign corner2_y_o = found_q ? cy_q[1] : '0;
  assign corner3_x_o = found_q ? cx_q[2] : '0;
  assign corner3_y_o = found_q ? cy_q[2] : '0;
  assign corner4_x_o = found_q ? cx_q[3] : '0;
  assign corner4_y_o = found_q ? cy_q[3] : '0;
  assign best_angle_o = found_q ? mabr_pkg::AngleW'(best_ang_q) : '0;
  assign best_area_o  = best_area_q[mabr_pkg::AreaW-1:0];
  assign found_o      = found_q;

  `ASSERT_NEVER_BOTH(a_done_busy_start, clk_i, rst_ni, done_o, rd_q,
    "result strobe while a point read is still in flight")
  `ASSERT_IMPL(a_count_cap, clk_i, rst_ni, count_q <= CntW'(MaxPoints),
    "point count beyond capacity")
  `ASSERT_IMPL(a_emit_clears, clk_i, rst_ni, done_o |=> (count_q == '0),
    "point count not cleared after a result")

endmodule
